@@ hdl/gdse_pkg.sv @@
// Package with the types and codes of the graph degree statistics engine.
`timescale 1ns / 1ps

package gdse_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_INSERT  = 2'd1,
    OP_ANALYZE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_WA,
    ST_INS_WB,
    ST_SCAN,
    ST_ROW_LAST,
    ST_ROW_EMIT,
    ST_SUMMARY
  } state_e;

  localparam logic REG_DIRECTED  = 1'b0;
  localparam logic REG_NUM_NODES = 1'b1;

  localparam int unsigned NodeW   = 4;
  localparam int unsigned DegreeW = 12;
  localparam int unsigned CountW  = 5;
  localparam int unsigned ParW    = 7;
  localparam int unsigned NumW    = 5;

  typedef struct packed {
    logic [5:0]       pad;
    logic [NodeW-1:0] dst_node;
    logic [NodeW-1:0] src_node;
    logic [1:0]       op;
  } in_t;

  typedef struct packed {
    logic [2:0]         pad;
    logic [DegreeW-1:0] min_degree;
    logic [DegreeW-1:0] max_degree;
    logic               is_complete;
    logic               is_regular;
    logic [ParW-1:0]    parallel_count;
    logic [CountW-1:0]  loop_count;
    logic [CountW-1:0]  isolated_count;
    logic               is_isolated;
    logic               has_loop;
    logic [DegreeW-1:0] degree;
    logic [NodeW-1:0]   node;
  } rec_t;

endpackage

@@ hdl/graph_degree_stats_engine.sv @@
// Adjacency matrix of saturating edge counts with per-node degree statistics.
//
//  Channel   Direction  Signals                          Contents
//  s_axis    in         tvalid tready tdata[15:0]        op, src_node, dst_node
//  m_axis    out        tvalid tready tdata[63:0] tlast  per-node record or summary
//  apb       in/out     psel penable pwrite paddr[2:0]   directed, num_nodes
//
// Insert writes one cell (directed edge or self-loop) or two (mirrored edge),
// one after the other through the single write port of the cell memory.
// Clear writes zero to all MAX_NODES*MAX_NODES cells (256 by default).
// Analyze scans the n nodes in use row by row, one cell pair read per cycle within a row.
// After reset the same sweep clears all MAX_NODES*MAX_NODES cells first.
// A stalled output holds the scan at the end of a row until the record is taken.
`timescale 1ns / 1ps

module graph_degree_stats_engine #(
  parameter int unsigned MAX_NODES  = 16,
  parameter int unsigned CELL_WIDTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], src_node[5:2], dst_node[9:6], zero fill.
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // node[3:0], degree[15:4], has_loop[16], is_isolated[17], isolated_count[22:18],
  // loop_count[27:23], parallel_count[34:28], is_regular[35], is_complete[36],
  // max_degree[48:37], min_degree[60:49], zero fill.
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gdse_pkg::*;

  localparam int unsigned Depth = MAX_NODES * MAX_NODES;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned IW    = $clog2(MAX_NODES);
  localparam int unsigned NW    = $clog2(MAX_NODES + 1);
  localparam int unsigned CW    = (NW > NumW) ? NW : NumW;
  localparam int unsigned DW    = CELL_WIDTH + NW;
  localparam int unsigned PW    = $clog2(Depth + 1);

  logic [CELL_WIDTH-1:0] mem [Depth];

  state_e state_q, state_d;
  logic   directed_q;
  logic [NumW-1:0] num_nodes_q;
  logic [NW-1:0]   n_use;
  logic [CW-1:0]   nn_ext;

  logic [AW-1:0] clr_cnt_q;
  logic [AW-1:0] rd_addr_a, rd_addr_b, wr_addr;
  logic [AW-1:0] ins_addr_a_q, ins_addr_b_q;
  logic          two_q;
  logic [1:0]    amt_q;
  logic [CELL_WIDTH-1:0] rd_a_q, rd_b_q, wr_data;
  logic          rd_en, mem_we;
  logic [CELL_WIDTH:0] sum_a, sum_b;
  logic [CELL_WIDTH-1:0] sat_a, sat_b;

  logic [IW-1:0] row_q, col_q, acc_col_q;
  logic          acc_en_q;
  logic [DW-1:0] deg_q, max_q, min_q;
  logic          lp_q, regular_q, complete_q;
  logic [NW-1:0] iso_q, loops_q;
  logic [PW-1:0] par_q;

  logic          out_valid_q, out_last_q, out_free;
  logic          emit_row, emit_sum;
  rec_t          out_q, rec;
  in_t           in_w;
  logic [IW-1:0] in_src, in_dst;
  logic          accept, in_range, col_last, row_last, clr_last, cfg_we;

  assign in_w   = in_t'(s_axis_tdata);
  assign in_src = IW'(in_w.src_node);
  assign in_dst = IW'(in_w.dst_node);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign emit_row = (state_q == ST_ROW_EMIT) && out_free;
  assign emit_sum = (state_q == ST_SUMMARY) && out_free;

  assign nn_ext = CW'(num_nodes_q);
  always_comb begin
    if (num_nodes_q == '0) begin
      n_use = NW'(1);
    end else if (nn_ext > CW'(MAX_NODES)) begin
      n_use = NW'(MAX_NODES);
    end else begin
      n_use = NW'(nn_ext);
    end
  end

  assign in_range = (CW'(in_w.src_node) < CW'(n_use)) && (CW'(in_w.dst_node) < CW'(n_use));
  assign col_last = (NW'(col_q) + NW'(1)) == n_use;
  assign row_last = (NW'(row_q) + NW'(1)) == n_use;
  assign clr_last = clr_cnt_q == AW'(Depth - 1);

  assign sum_a = {1'b0, rd_a_q} + {{(CELL_WIDTH - 1){1'b0}}, amt_q};
  assign sum_b = {1'b0, rd_b_q} + {{CELL_WIDTH{1'b0}}, 1'b1};
  assign sat_a = sum_a[CELL_WIDTH] ? '1 : sum_a[CELL_WIDTH-1:0];
  assign sat_b = sum_b[CELL_WIDTH] ? '1 : sum_b[CELL_WIDTH-1:0];

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  always_comb begin
    unique case (paddr[2])
      REG_DIRECTED:  prdata = {31'd0, directed_q};
      REG_NUM_NODES: prdata = {{(32 - NumW){1'b0}}, num_nodes_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      directed_q  <= 1'b0;
      num_nodes_q <= NumW'(16);
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_DIRECTED:  directed_q  <= pwdata[0];
        REG_NUM_NODES: num_nodes_q <= pwdata[NumW-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (in_w.op)
            OP_CLEAR:   state_d = ST_CLEAR;
            OP_INSERT:  if (in_range) state_d = ST_INS_WA;
            OP_ANALYZE: state_d = ST_SCAN;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_INS_WA:   state_d = two_q ? ST_INS_WB : ST_IDLE;
      ST_INS_WB:   state_d = ST_IDLE;
      ST_SCAN:     if (col_last) state_d = ST_ROW_LAST;
      ST_ROW_LAST: state_d = ST_ROW_EMIT;
      ST_ROW_EMIT: if (out_free) state_d = row_last ? ST_SUMMARY : ST_SCAN;
      ST_SUMMARY:  if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Memory control.
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    mem_we        = 1'b0;
    rd_addr_a     = AW'(row_q) * AW'(MAX_NODES) + AW'(col_q);
    rd_addr_b     = AW'(col_q) * AW'(MAX_NODES) + AW'(row_q);
    wr_addr       = clr_cnt_q;
    wr_data       = '0;
    unique case (state_q)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        rd_en         = 1'b1;
        rd_addr_a     = AW'(in_src) * AW'(MAX_NODES) + AW'(in_dst);
        rd_addr_b     = AW'(in_dst) * AW'(MAX_NODES) + AW'(in_src);
      end
      ST_INS_WA: begin
        mem_we  = 1'b1;
        wr_addr = ins_addr_a_q;
        wr_data = sat_a;
      end
      ST_INS_WB: begin
        mem_we  = 1'b1;
        wr_addr = ins_addr_b_q;
        wr_data = sat_b;
      end
      ST_SCAN: rd_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= mem[rd_addr_a];
      rd_b_q <= mem[rd_addr_b];
    end
  end

  always_comb begin
    rec = '0;
    if (state_q == ST_SUMMARY) begin
      rec.isolated_count = CountW'(iso_q);
      rec.loop_count     = CountW'(loops_q);
      rec.parallel_count = ParW'(par_q >> 1);
      rec.is_regular     = regular_q;
      rec.is_complete    = complete_q;
      rec.max_degree     = DegreeW'(max_q);
      rec.min_degree     = DegreeW'(min_q);
    end else begin
      rec.node        = NodeW'(row_q);
      rec.degree      = DegreeW'(deg_q);
      rec.has_loop    = lp_q;
      rec.is_isolated = deg_q == '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      row_q       <= '0;
      col_q       <= '0;
      acc_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      acc_en_q <= state_q == ST_SCAN;
      if (emit_row || emit_sum) begin
        out_valid_q <= 1'b1;
        out_last_q  <= emit_sum;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: clr_cnt_q <= clr_last ? '0 : clr_cnt_q + AW'(1);
        ST_IDLE: begin
          row_q <= '0;
          col_q <= '0;
        end
        ST_SCAN: if (!col_last) col_q <= col_q + IW'(1);
        ST_ROW_EMIT: begin
          if (out_free) begin
            col_q <= '0;
            if (!row_last) row_q <= row_q + IW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      ins_addr_a_q <= rd_addr_a;
      ins_addr_b_q <= rd_addr_b;
      two_q        <= !directed_q && (in_src != in_dst);
      amt_q        <= (!directed_q && (in_src == in_dst)) ? 2'd2 : 2'd1;
      deg_q        <= '0;
      lp_q         <= 1'b0;
      iso_q        <= '0;
      loops_q      <= '0;
      par_q        <= '0;
      regular_q    <= 1'b1;
      complete_q   <= 1'b1;
    end
    acc_col_q <= col_q;
    if (acc_en_q) begin
      deg_q <= deg_q + DW'(rd_a_q);
      if (acc_col_q == row_q) begin
        lp_q <= rd_a_q != '0;
      end else begin
        if (rd_a_q > CELL_WIDTH'(1)) par_q <= par_q + PW'(1);
        if (rd_a_q == '0 && rd_b_q == '0) complete_q <= 1'b0;
      end
    end
    if (emit_row || emit_sum) begin
      out_q <= rec;
    end
    if (emit_row) begin
      deg_q <= '0;
      lp_q  <= 1'b0;
      if (deg_q == '0) iso_q <= iso_q + NW'(1);
      if (lp_q) loops_q <= loops_q + NW'(1);
      if (row_q == '0) begin
        max_q <= deg_q;
        min_q <= deg_q;
      end else begin
        if (deg_q != max_q || deg_q != min_q) regular_q <= 1'b0;
        if (deg_q > max_q) max_q <= deg_q;
        if (deg_q < min_q) min_q <= deg_q;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_last_q;

  a_analyze_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_w.op == OP_ANALYZE) |=> state_q == ST_SCAN)
    else $error("Analyze did not start the scan.");

  a_acc_follows_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_en_q |-> $past(state_q) == ST_SCAN)
    else $error("Accumulation without a scan read.");

  a_row_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROW_EMIT && out_free) |=> (m_axis_tvalid && !m_axis_tlast))
    else $error("Row record was not presented.");

  a_summary_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUMMARY && out_free) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("Summary record was not presented.");

endmodule

@@ tb/graph_degree_stats_engine_test.sv @@
// Self-checking testbench for the graph degree statistics engine.
`timescale 1ns / 1ps

module graph_degree_stats_engine_test;
  import gdse_pkg::*;

  localparam int MAX_NODES = 16;
  localparam int CELL_MAX = 255;
  localparam int SETTLE_CYCLES = 300;
  localparam int DRAIN_LIMIT = 100000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct packed {
    logic last;
    rec_t rec;
  } degree_rec_t;

  typedef struct packed {
    row_kind_e  kind;
    in_t        item;
    logic       reg_sel;
    logic [4:0] value;
    logic       typed;
    rec_t       summary;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [7:0]  cell_q [MAX_NODES][MAX_NODES];
  logic        dir_q;
  logic [4:0]  nodes_q;
  degree_rec_t pending_records [$];
  stim_row_t   stim_table [$];
  int          mismatch_count = 0;
  int          send_idle_pct = 28;
  int          recv_idle_pct = 54;
  degree_rec_t want_rec;
  degree_rec_t got_rec;

  graph_degree_stats_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_rec.rec = rec_t'(m_axis_tdata);
      got_rec.last = m_axis_tlast;
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record expected none actual %h last %b", $time,
                 m_axis_tdata, m_axis_tlast);
        mismatch_count++;
      end else begin
        want_rec = pending_records.pop_front();
        compare_field("node", 16'(want_rec.rec.node), 16'(got_rec.rec.node));
        compare_field("degree", 16'(want_rec.rec.degree), 16'(got_rec.rec.degree));
        compare_field("has_loop", 16'(want_rec.rec.has_loop), 16'(got_rec.rec.has_loop));
        compare_field("is_isolated", 16'(want_rec.rec.is_isolated),
                      16'(got_rec.rec.is_isolated));
        compare_field("isolated_count", 16'(want_rec.rec.isolated_count),
                      16'(got_rec.rec.isolated_count));
        compare_field("loop_count", 16'(want_rec.rec.loop_count),
                      16'(got_rec.rec.loop_count));
        compare_field("parallel_count", 16'(want_rec.rec.parallel_count),
                      16'(got_rec.rec.parallel_count));
        compare_field("is_regular", 16'(want_rec.rec.is_regular),
                      16'(got_rec.rec.is_regular));
        compare_field("is_complete", 16'(want_rec.rec.is_complete),
                      16'(got_rec.rec.is_complete));
        compare_field("max_degree", 16'(want_rec.rec.max_degree),
                      16'(got_rec.rec.max_degree));
        compare_field("min_degree", 16'(want_rec.rec.min_degree),
                      16'(got_rec.rec.min_degree));
        compare_field("last", 16'(want_rec.last), 16'(got_rec.last));
      end
    end
  end

  function automatic int unsigned active_nodes();
    if (nodes_q == '0) return 1;
    if (int'(nodes_q) > MAX_NODES) return MAX_NODES;
    return 32'(nodes_q);
  endfunction

  function automatic void add_edge(input int row, input int col, input int amount);
    int sum;
    sum = int'(cell_q[row][col]) + amount;
    cell_q[row][col] = (sum > CELL_MAX) ? 8'(CELL_MAX) : 8'(sum);
  endfunction

  // Updates the matrix copy and queues the records an analyze produces.
  // Returns 0 for a transaction that the engine ignores.
  function automatic bit apply_graph_op(input in_t it);
    int unsigned n, deg, iso, loops, par, maxd, mind;
    bit regular, complete, lp;
    degree_rec_t r;
    n = active_nodes();
    iso = 0;
    loops = 0;
    par = 0;
    maxd = 0;
    mind = 0;
    regular = 1'b1;
    complete = 1'b1;
    case (it.op)
      OP_CLEAR: begin
        foreach (cell_q[i, j]) cell_q[i][j] = '0;
        return 1'b1;
      end
      OP_INSERT: begin
        if (32'(it.src_node) >= n || 32'(it.dst_node) >= n) return 1'b0;
        if (dir_q) begin
          add_edge(int'(it.src_node), int'(it.dst_node), 1);
        end else if (it.src_node == it.dst_node) begin
          add_edge(int'(it.src_node), int'(it.src_node), 2);
        end else begin
          add_edge(int'(it.src_node), int'(it.dst_node), 1);
          add_edge(int'(it.dst_node), int'(it.src_node), 1);
        end
        return 1'b1;
      end
      OP_ANALYZE: begin
        for (int i = 0; i < n; i++) begin
          deg = 0;
          for (int j = 0; j < n; j++) deg += 32'(cell_q[i][j]);
          lp = (cell_q[i][i] != 0);
          r = '0;
          r.rec.node = 4'(i);
          r.rec.degree = 12'(deg);
          r.rec.has_loop = lp;
          r.rec.is_isolated = (deg == 0);
          pending_records.push_back(r);
          if (deg == 0) iso++;
          if (lp) loops++;
          if (i == 0) begin
            maxd = deg;
            mind = deg;
          end else begin
            if (deg != maxd || deg != mind) regular = 1'b0;
            if (deg > maxd) maxd = deg;
            if (deg < mind) mind = deg;
          end
          for (int j = 0; j < n; j++) begin
            if (j != i) begin
              if (cell_q[i][j] > 1) par++;
              if (cell_q[i][j] == 0 && cell_q[j][i] == 0) complete = 1'b0;
            end
          end
        end
        r = '0;
        r.rec.isolated_count = 5'(iso);
        r.rec.loop_count = 5'(loops);
        r.rec.parallel_count = 7'(par / 2);
        r.rec.is_regular = regular;
        r.rec.is_complete = complete;
        r.rec.max_degree = 12'(maxd);
        r.rec.min_degree = 12'(mind);
        r.last = 1'b1;
        pending_records.push_back(r);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic push_item(input in_t it, input logic typed, input rec_t summary);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= it;
    do @(posedge clk_i); while (!s_axis_tready);
    void'(apply_graph_op(it));
    if (typed) pending_records[pending_records.size() - 1].rec = summary;
  endtask

  // Holds the sender until every queued record has come back, then lets a
  // clear sweep finish.
  task automatic settle();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_records.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_records.size() != 0) begin
      $display("%0t: records expected %0d actual 0 arrived", $time, pending_records.size());
      mismatch_count++;
      pending_records.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic sel, input logic [4:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    if (sel == REG_DIRECTED) dir_q = value[0];
    else nodes_q = value;
  endtask

  function automatic in_t make_item(input logic [1:0] op, input logic [3:0] src,
                                    input logic [3:0] dst);
    in_t it;
    it = '0;
    it.op = op;
    it.src_node = src;
    it.dst_node = dst;
    return it;
  endfunction

  function automatic stim_row_t op_row(input logic [1:0] op, input logic [3:0] src,
                                       input logic [3:0] dst);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item = make_item(op, src, dst);
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic sel, input logic [4:0] value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_sel = sel;
    row.value = value;
    return row;
  endfunction

  function automatic stim_row_t summary_row(input int iso, input int loops,
                                            input int regular, input int complete,
                                            input int maxd, input int mind);
    stim_row_t row;
    row = op_row(OP_ANALYZE, 4'd0, 4'd0);
    row.typed = 1'b1;
    row.summary.isolated_count = 5'(iso);
    row.summary.loop_count = 5'(loops);
    row.summary.is_regular = 1'(regular);
    row.summary.is_complete = 1'(complete);
    row.summary.max_degree = 12'(maxd);
    row.summary.min_degree = 12'(mind);
    return row;
  endfunction

  function automatic logic [4:0] random_node_count();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 5'($urandom_range(1, 6));
    if (pick < 88) return 5'($urandom_range(7, 16));
    if (pick < 93) return 5'd0;
    return 5'($urandom_range(17, 31));
  endfunction

  // One graph: optional new settings, optional clear, a batch of mostly edge inserts, analyze.
  task automatic run_graph(input bit saturate, inout int items_taken);
    int n_edges, pick, n, loop_node;
    in_t it;
    rec_t none;
    none = '0;
    if (saturate) begin
      settle();
      write_reg(REG_DIRECTED, 5'd0);
      write_reg(REG_NUM_NODES, 5'd3);
    end else if ($urandom_range(0, 99) < 50) begin
      settle();
      if ($urandom_range(0, 99) < 60) write_reg(REG_DIRECTED, 5'($urandom_range(0, 1)));
      if ($urandom_range(0, 99) < 80) write_reg(REG_NUM_NODES, random_node_count());
    end
    if (saturate || $urandom_range(0, 99) < 70) begin
      push_item(make_item(OP_CLEAR, 4'd0, 4'd0), 1'b0, none);
      items_taken++;
    end
    n = active_nodes();
    loop_node = $urandom_range(0, 2);
    n_edges = saturate ? 130 : $urandom_range(0, 12);
    for (int k = 0; k < n_edges; k++) begin
      pick = $urandom_range(0, 99);
      if (saturate) begin
        it = make_item(OP_INSERT, 4'(loop_node), 4'(loop_node));
      end else if (pick < 6) begin
        it = make_item(OP_UNUSED, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end else if (pick < 9) begin
        it = make_item(OP_CLEAR, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end else if (pick < 24) begin
        it = make_item(OP_INSERT, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end else begin
        it = make_item(OP_INSERT, 4'($urandom_range(0, n - 1)), 4'($urandom_range(0, n - 1)));
      end
      push_item(it, 1'b0, none);
      items_taken++;
    end
    push_item(make_item(OP_ANALYZE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))),
              1'b0, none);
    items_taken++;
  endtask

  initial begin
    int items_taken;
    dir_q = 1'b0;
    nodes_q = 5'd16;
    foreach (cell_q[i, j]) cell_q[i][j] = '0;

    stim_table.push_back(summary_row(16, 0, 1, 0, 0, 0));
    stim_table.push_back(reg_row(REG_NUM_NODES, 5'd1));
    stim_table.push_back(summary_row(1, 0, 1, 1, 0, 0));
    stim_table.push_back(op_row(OP_INSERT, 4'd0, 4'd0));
    stim_table.push_back(op_row(OP_INSERT, 4'd1, 4'd0));
    stim_table.push_back(op_row(OP_INSERT, 4'd15, 4'd15));
    stim_table.push_back(summary_row(0, 1, 1, 1, 2, 2));
    stim_table.push_back(op_row(OP_UNUSED, 4'd15, 4'd15));
    stim_table.push_back(reg_row(REG_NUM_NODES, 5'd0));
    stim_table.push_back(summary_row(0, 1, 1, 1, 2, 2));
    stim_table.push_back(reg_row(REG_NUM_NODES, 5'd31));
    stim_table.push_back(op_row(OP_INSERT, 4'd15, 4'd0));
    stim_table.push_back(op_row(OP_INSERT, 4'd0, 4'd15));
    stim_table.push_back(op_row(OP_ANALYZE, 4'd15, 4'd15));
    stim_table.push_back(reg_row(REG_DIRECTED, 5'd1));
    stim_table.push_back(op_row(OP_INSERT, 4'd10, 4'd5));
    stim_table.push_back(op_row(OP_INSERT, 4'd5, 4'd5));
    stim_table.push_back(op_row(OP_INSERT, 4'd5, 4'd10));
    stim_table.push_back(op_row(OP_ANALYZE, 4'd10, 4'd5));
    stim_table.push_back(op_row(OP_CLEAR, 4'd15, 4'd15));
    stim_table.push_back(summary_row(16, 0, 1, 0, 0, 0));
    stim_table.push_back(reg_row(REG_NUM_NODES, 5'd2));
    stim_table.push_back(reg_row(REG_DIRECTED, 5'd0));
    stim_table.push_back(op_row(OP_INSERT, 4'd0, 4'd1));
    stim_table.push_back(summary_row(0, 0, 1, 1, 1, 1));
    stim_table.push_back(reg_row(REG_NUM_NODES, 5'd17));
    stim_table.push_back(op_row(OP_ANALYZE, 4'd0, 4'd0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_REG) begin
        settle();
        write_reg(stim_table[i].reg_sel, stim_table[i].value);
      end else begin
        push_item(stim_table[i].item, stim_table[i].typed, stim_table[i].summary);
      end
    end

    items_taken = 0;
    while (items_taken < 40) run_graph(1'b0, items_taken);
    send_idle_pct = 54;
    recv_idle_pct = 28;
    while (items_taken < 80) run_graph(1'b0, items_taken);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_graph(1'b1, items_taken);
    while (items_taken < 230) run_graph(1'b0, items_taken);

    settle();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/gdse_pkg.sv
hdl/graph_degree_stats_engine.sv
tb/graph_degree_stats_engine_test.sv
